// File: hw/rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH    = 4;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_TWO  = 2'd2,
    KIND_ALL  = 2'd3
  } root_kind_t;

  // per-item control carried from front to back
  typedef struct packed {
    root_kind_t kind;
    logic       div_en;
  } job_ctl_t;

endpackage

// File: hw/rtl/quadratic_root_solver_core.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// Solves a*x^2 + b*x + c = 0 in signed fixed point, one item per cycle.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_coef_a, in_coef_b, in_coef_c
//   out_     output     out_valid / out_ready  out_root_kind, out_root_first,
//                                              out_root_second, out_saturated
//
// One item accepted per cycle when the output is drained. An item passes
// 2 (front, queue) + W+F+2 (square root) + W+F+3 (divider) + 1 (output)
// registers, 104 at the default widths, on the way to the output register.
// Front and back stall independently across a four-entry queue.
// Synchronous active-low reset clears only the valid bits and queue pointers and count.
// ----------------------------------------------------------------------------
module quadratic_root_solver_core import qrs_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COEF_WIDTH-1:0] in_coef_a,
  input  logic signed [COEF_WIDTH-1:0] in_coef_b,
  input  logic signed [COEF_WIDTH-1:0] in_coef_c,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_root_kind,
  output logic signed [COEF_WIDTH-1:0] out_root_first,
  output logic signed [COEF_WIDTH-1:0] out_root_second,
  output logic                         out_saturated
);

  localparam int W     = COEF_WIDTH;
  localparam int DW    = 2*W + 1;
  localparam int NBW   = W + FRAC_BITS + 1;
  localparam int CTLW  = $bits(job_ctl_t);
  localparam int JOBW  = CTLW + DW + NBW + W + 1;

  logic                  f_valid, f_ready;
  job_ctl_t              f_ctl, b_ctl;
  logic [DW-1:0]         f_disc, b_disc;
  logic signed [NBW-1:0] f_num, b_num;
  logic signed [W:0]     f_den, b_den;
  logic                  b_valid, b_ready;
  logic [JOBW-1:0]       q_rd;

  qrs_front #(
    .COEF_WIDTH (COEF_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_a      (in_coef_a),
    .in_b      (in_coef_b),
    .in_c      (in_coef_c),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job_ctl   (f_ctl),
    .job_disc  (f_disc),
    .job_num   (f_num),
    .job_den   (f_den)
  );

  qrs_fifo #(
    .DATA_W (JOBW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  ({f_ctl, f_disc, f_num, f_den}),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (q_rd)
  );

  assign {b_ctl, b_disc, b_num, b_den} = q_rd;

  qrs_back #(
    .COEF_WIDTH (COEF_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (b_valid),
    .job_ready       (b_ready),
    .job_ctl         (b_ctl),
    .job_disc        (b_disc),
    .job_num         (b_num),
    .job_den         (b_den),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_root_kind   (out_root_kind),
    .out_root_first  (out_root_first),
    .out_root_second (out_root_second),
    .out_saturated   (out_saturated)
  );

  // items without computed roots carry zero roots and no clipping
  a_no_roots_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_root_kind == KIND_NONE || out_root_kind == KIND_ALL)
      |-> out_root_first == '0 && out_root_second == '0 && !out_saturated)
    else $error("root fields set on a rootless item");

  a_single_root_equal : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_kind == KIND_ONE |-> out_root_first == out_root_second)
    else $error("linear item with differing roots");

  a_queue_moves : assert property (@(posedge clk) disable iff (!rst_n)
    f_valid && !f_ready |-> b_valid)
    else $error("queue refuses an item while empty");

endmodule

// File: hw/rtl/qrs_fifo.sv
// ----------------------------------------------------------------------------
// qrs_fifo
// Short queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module qrs_fifo import qrs_pkg::*; #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [DATA_W-1:0] mem_r [0:QUEUE_DEPTH-1];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]       count_r, count_nxt;
  logic              push, pop;

  assign wr_ready = (count_r != (PW+1)'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: hw/rtl/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front
// Takes coefficient items, forms b^2 and |ac|, then classifies the equation
// and builds the discriminant, scaled numerator and denominator.
// ----------------------------------------------------------------------------
module qrs_front import qrs_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COEF_WIDTH-1:0] in_a,
  input  logic signed [COEF_WIDTH-1:0] in_b,
  input  logic signed [COEF_WIDTH-1:0] in_c,
  output logic                         job_valid,
  input  logic                         job_ready,
  output job_ctl_t                     job_ctl,
  output logic [2*COEF_WIDTH:0]        job_disc,
  output logic signed [COEF_WIDTH+FRAC_BITS:0] job_num,
  output logic signed [COEF_WIDTH:0]   job_den
);

  localparam int W   = COEF_WIDTH;
  localparam int DW  = 2*W + 1;
  localparam int NBW = W + FRAC_BITS + 1;

  logic                s1_v_r;
  logic signed [W-1:0] s1_a_r, s1_b_r, s1_c_r;
  logic [2*W-1:0]      s1_bsq_r, s1_ac_r;
  logic [W-1:0]        a_mag, b_mag, c_mag;
  logic                en;

  assign en       = !s1_v_r || job_ready;
  assign in_ready = en;

  always_comb begin
    a_mag = in_a[W-1] ? W'(-in_a) : W'(in_a);
    b_mag = in_b[W-1] ? W'(-in_b) : W'(in_b);
    c_mag = in_c[W-1] ? W'(-in_c) : W'(in_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r   <= in_a;
      s1_b_r   <= in_b;
      s1_c_r   <= in_c;
      s1_bsq_r <= b_mag * b_mag;
      s1_ac_r  <= a_mag * c_mag;
    end
  end

  logic                  a_zero, b_zero, c_zero, acpos, negd;
  logic [2*W+1:0]        bsq_x, ac4, dsum;
  logic signed [NBW-1:0] nb_b, nb_c;

  always_comb begin
    a_zero = (s1_a_r == '0);
    b_zero = (s1_b_r == '0);
    c_zero = (s1_c_r == '0);
    acpos  = !c_zero && (s1_a_r[W-1] == s1_c_r[W-1]);
    bsq_x  = (2*W+2)'(s1_bsq_r);
    ac4    = {s1_ac_r, 2'b00};
    negd   = acpos && (bsq_x < ac4);
    dsum   = acpos ? bsq_x - ac4 : bsq_x + ac4;
    nb_b   = -(NBW'(s1_b_r) <<< FRAC_BITS);
    nb_c   = -(NBW'(s1_c_r) <<< FRAC_BITS);

    job_ctl.kind   = KIND_NONE;
    job_ctl.div_en = 1'b0;
    job_disc       = '0;
    job_num        = nb_b;
    job_den        = {s1_a_r, 1'b0};
    if (a_zero) begin
      // linear: zero discriminant leaves the root as plain -c/b
      job_num = nb_c;
      job_den = (W+1)'(s1_b_r);
      if (!b_zero) begin
        job_ctl.kind   = KIND_ONE;
        job_ctl.div_en = 1'b1;
      end else if (c_zero) begin
        job_ctl.kind = KIND_ALL;
      end
    end else if (!negd) begin
      job_ctl.kind   = KIND_TWO;
      job_ctl.div_en = 1'b1;
      job_disc       = dsum[DW-1:0];
    end
  end

  assign job_valid = s1_v_r;

endmodule

// File: hw/rtl/qrs_back.sv
// ----------------------------------------------------------------------------
// qrs_back
// Pipelined arithmetic: digit-by-digit square root, then two restoring
// dividers side by side, then sign and clipping into the output register.
// ----------------------------------------------------------------------------
module qrs_back import qrs_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  output logic                         job_ready,
  input  job_ctl_t                     job_ctl,
  input  logic [2*COEF_WIDTH:0]        job_disc,
  input  logic signed [COEF_WIDTH+FRAC_BITS:0] job_num,
  input  logic signed [COEF_WIDTH:0]   job_den,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_root_kind,
  output logic signed [COEF_WIDTH-1:0] out_root_first,
  output logic signed [COEF_WIDTH-1:0] out_root_second,
  output logic                         out_saturated
);

  localparam int W    = COEF_WIDTH;
  localparam int NBW  = W + FRAC_BITS + 1;   // scaled -b or -c
  localparam int RW   = W + FRAC_BITS + 1;   // square root bits
  localparam int XW   = 2 * RW;              // radicand bits
  localparam int RMW  = RW + 2;              // root remainder
  localparam int NW   = W + FRAC_BITS + 2;   // numerator magnitude
  localparam int NSW  = NW + 1;
  localparam int DNW  = W + 1;               // denominator magnitude

  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_ready;
  assign job_ready = en;

  // ---------------- square root stages ----------------
  logic                  sq_v_r    [0:RW];
  job_ctl_t              sq_ctl_r  [0:RW];
  logic [RMW-1:0]        sq_rem_r  [0:RW];
  logic [RW-1:0]         sq_root_r [0:RW];
  logic [XW-1:0]         sq_rad_r  [0:RW];
  logic signed [NBW-1:0] sq_num_r  [0:RW];
  logic signed [W:0]     sq_den_r  [0:RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_ctl_r[0]  <= job_ctl;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_rad_r[0]  <= XW'(job_disc) << (2 * FRAC_BITS);
      sq_num_r[0]  <= job_num;
      sq_den_r[0]  <= job_den;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sq
    logic [RMW+1:0] t, sub;
    logic           ge;
    always_comb begin
      t   = {sq_rem_r[k], sq_rad_r[k][XW-1 -: 2]};
      sub = (RMW+2)'({sq_root_r[k], 2'b01});
      ge  = (t >= sub);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_ctl_r[k+1]  <= sq_ctl_r[k];
        sq_rem_r[k+1]  <= ge ? RMW'(t - sub) : RMW'(t);
        sq_root_r[k+1] <= {sq_root_r[k][RW-2:0], ge};
        sq_rad_r[k+1]  <= sq_rad_r[k] << 2;
        sq_num_r[k+1]  <= sq_num_r[k];
        sq_den_r[k+1]  <= sq_den_r[k];
      end
    end
  end

  // ---------------- numerator forming ----------------
  logic signed [NSW-1:0] num1, num2;
  logic                  den_neg;
  logic                  nm_v_r;
  job_ctl_t              nm_ctl_r;
  logic [NW-1:0]         nm_mag_r [0:1];
  logic                  nm_neg_r [0:1];
  logic [DNW-1:0]        nm_dmag_r;

  always_comb begin
    num1    = NSW'(sq_num_r[RW]) - $signed(NSW'(sq_root_r[RW]));
    num2    = NSW'(sq_num_r[RW]) + $signed(NSW'(sq_root_r[RW]));
    den_neg = sq_den_r[RW][W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_v_r <= 1'b0;
    end else if (en) begin
      nm_v_r <= sq_v_r[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_ctl_r    <= sq_ctl_r[RW];
      nm_mag_r[0] <= num1[NSW-1] ? NW'(-num1) : NW'(num1);
      nm_mag_r[1] <= num2[NSW-1] ? NW'(-num2) : NW'(num2);
      nm_neg_r[0] <= num1[NSW-1] ^ den_neg;
      nm_neg_r[1] <= num2[NSW-1] ^ den_neg;
      nm_dmag_r   <= den_neg ? DNW'(-sq_den_r[RW]) : DNW'(sq_den_r[RW]);
    end
  end

  // ---------------- divider stages, two lanes ----------------
  logic           dv_v_r    [0:NW];
  job_ctl_t       dv_ctl_r  [0:NW];
  logic [DNW-1:0] dv_dmag_r [0:NW];
  logic [DNW-1:0] dv_rem_r  [0:NW][0:1];
  logic [NW-1:0]  dv_num_r  [0:NW][0:1];
  logic [NW-1:0]  dv_q_r    [0:NW][0:1];
  logic           dv_neg_r  [0:NW][0:1];

  always_comb begin
    dv_v_r[0]    = nm_v_r;
    dv_ctl_r[0]  = nm_ctl_r;
    dv_dmag_r[0] = nm_dmag_r;
    for (int l = 0; l < 2; l++) begin
      dv_rem_r[0][l] = '0;
      dv_num_r[0][l] = nm_mag_r[l];
      dv_q_r[0][l]   = '0;
      dv_neg_r[0][l] = nm_neg_r[l];
    end
  end

  for (genvar j = 0; j < NW; j++) begin : g_dv
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_ctl_r[j+1]  <= dv_ctl_r[j];
        dv_dmag_r[j+1] <= dv_dmag_r[j];
      end
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DNW:0] t;
      logic         ge;
      always_comb begin
        t  = {dv_rem_r[j][l], dv_num_r[j][l][NW-1]};
        ge = (t >= {1'b0, dv_dmag_r[j]});
      end
      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem_r[j+1][l] <= ge ? DNW'(t - {1'b0, dv_dmag_r[j]}) : DNW'(t);
          dv_num_r[j+1][l] <= dv_num_r[j][l] << 1;
          dv_q_r[j+1][l]   <= {dv_q_r[j][l][NW-2:0], ge};
          dv_neg_r[j+1][l] <= dv_neg_r[j][l];
        end
      end
    end
  end

  // ---------------- sign, clipping and output register ----------------
  logic [NW-1:0]       lim   [0:1];
  logic [NW-1:0]       qclip [0:1];
  logic                sat   [0:1];
  logic signed [W-1:0] root  [0:1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      lim[l]   = (NW'(1) << (W-1)) - NW'(!dv_neg_r[NW][l]);
      sat[l]   = dv_q_r[NW][l] > lim[l];
      qclip[l] = sat[l] ? lim[l] : dv_q_r[NW][l];
      root[l]  = dv_neg_r[NW][l] ? W'(-qclip[l]) : W'(qclip[l]);
    end
  end

  logic [1:0]          out_kind_r;
  logic signed [W-1:0] out_first_r, out_second_r;
  logic                out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v_r[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_kind_r   <= dv_ctl_r[NW].kind;
      out_first_r  <= dv_ctl_r[NW].div_en ? root[0] : '0;
      out_second_r <= dv_ctl_r[NW].div_en ? root[1] : '0;
      out_sat_r    <= dv_ctl_r[NW].div_en && (sat[0] || sat[1]);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_root_kind   = out_kind_r;
  assign out_root_first  = out_first_r;
  assign out_root_second = out_second_r;
  assign out_saturated   = out_sat_r;

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for quadratic_root_solver_core: directed corner items, then
// random coefficient sets with random idling on both sides. Each result is
// checked field by field against a local model of the solver.
// ----------------------------------------------------------------------------
module tb;
  import qrs_pkg::*;

  localparam int W         = COEF_WIDTH_DEF;
  localparam int F         = FRAC_BITS_DEF;
  localparam int LATENCY   = 2 + (W + F + 2) + (W + F + 3) + 1;
  localparam int IDLE_LIMIT = 20 * LATENCY;
  localparam logic signed [W-1:0] Q_ONE = 1 <<< F;
  localparam logic signed [W-1:0] Q_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] Q_MIN = {1'b1, {(W-1){1'b0}}};

  typedef struct {
    root_kind_t      kind;
    logic [W-1:0]    first;
    logic [W-1:0]    second;
    logic            sat;
  } root_set_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic signed [W-1:0] in_coef_a;
  logic signed [W-1:0] in_coef_b;
  logic signed [W-1:0] in_coef_c;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          out_root_kind;
  logic signed [W-1:0] out_root_first;
  logic signed [W-1:0] out_root_second;
  logic                out_saturated;

  root_set_t pending_roots[$];
  int        err_cnt;
  int        idle_cycles;
  bit        no_idle;

  quadratic_root_solver_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_coef_a       (in_coef_a),
    .in_coef_b       (in_coef_b),
    .in_coef_c       (in_coef_c),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_root_kind   (out_root_kind),
    .out_root_first  (out_root_first),
    .out_root_second (out_root_second),
    .out_saturated   (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // truncating divide with clipping to the signed coefficient range
  function automatic logic [W-1:0] div_clip(longint num, longint den, inout logic sat);
    logic [63:0] nm;
    logic [63:0] dm;
    logic [63:0] q;
    logic [63:0] lim;
    logic        neg;
    nm  = (num < 0) ? -num : num;
    dm  = (den < 0) ? -den : den;
    q   = nm / dm;
    neg = (num < 0) != (den < 0);
    lim = neg ? (64'd1 << (W - 1)) : ((64'd1 << (W - 1)) - 1);
    if (q > lim) begin
      q   = lim;
      sat = 1'b1;
    end
    if (neg) q = 64'd0 - q;
    return q[W-1:0];
  endfunction

  function automatic root_set_t solve_roots(logic signed [W-1:0] a, logic signed [W-1:0] b,
                                            logic signed [W-1:0] c);
    root_set_t           r;
    logic signed [127:0] aw;
    logic signed [127:0] bw;
    logic signed [127:0] cw;
    logic signed [127:0] disc;
    logic [127:0]        rad;
    logic [63:0]         root;
    logic [63:0]         t;
    longint              nb;
    logic                sat;
    r   = '{KIND_NONE, '0, '0, 1'b0};
    sat = 1'b0;
    if (a == 0) begin
      if (b != 0) begin
        r.kind   = KIND_ONE;
        r.first  = div_clip(-(longint'(c) * (longint'(1) << F)), longint'(b), sat);
        r.second = r.first;
      end else if (c == 0) begin
        r.kind = KIND_ALL;
      end
    end else begin
      aw   = a;
      bw   = b;
      cw   = c;
      disc = bw * bw - 4 * aw * cw;
      if (disc >= 0) begin
        rad  = disc <<< (2 * F);
        root = '0;
        for (int i = 63; i >= 0; i--) begin
          t = root | (64'd1 << i);
          if ({64'd0, t} * {64'd0, t} <= rad) root = t;
        end
        nb       = -(longint'(b) * (longint'(1) << F));
        r.kind   = KIND_TWO;
        r.first  = div_clip(nb - longint'(root), 2 * longint'(a), sat);
        r.second = div_clip(nb + longint'(root), 2 * longint'(a), sat);
      end
    end
    r.sat = sat;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic signed [W-1:0] a, logic signed [W-1:0] b,
                           logic signed [W-1:0] c);
    int gap;
    @(negedge clk);
    in_valid  = 1'b1;
    in_coef_a = a;
    in_coef_b = b;
    in_coef_c = c;
    do @(posedge clk); while (!in_ready);
    pending_roots.push_back(solve_roots(a, b, c));
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    // drop valid first, or the last item would be taken again
    if (in_valid) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    while (pending_roots.size() != 0) @(posedge clk);
  endtask

  // result side back-pressure
  initial begin
    int stall;
    out_ready = 1'b0;
    stall     = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
        stall     = pick_gap();
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    root_set_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_roots.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result: kind %0d", out_root_kind);
      end else begin
        exp_r = pending_roots.pop_front();
        if (out_root_kind !== exp_r.kind || out_root_first !== exp_r.first ||
            out_root_second !== exp_r.second || out_saturated !== exp_r.sat) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp kind %0d r1 %h r2 %h sat %b, got kind %0d r1 %h r2 %h sat %b",
                     exp_r.kind, exp_r.first, exp_r.second, exp_r.sat, out_root_kind,
                     out_root_first, out_root_second, out_saturated);
        end
      end
    end
  end

  // watchdog: no handshake on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(0, 0, 0);                          // every number a root
    send_item(0, 0, Q_ONE);                      // no equation
    send_item(0, 0, Q_MIN);
    send_item(0, 2 * Q_ONE, -4 * Q_ONE);         // linear
    send_item(0, -3 * Q_ONE, Q_ONE);
    send_item(0, 1, Q_MAX);                      // linear, clipped low
    send_item(0, -1, Q_MAX);                     // linear, clipped high
    send_item(0, Q_MIN, Q_MIN);
    send_item(Q_ONE, 2 * Q_ONE, Q_ONE);          // double root
    send_item(Q_ONE, 0, Q_ONE);                  // negative discriminant
    send_item(Q_ONE, 0, -Q_ONE);
    send_item(Q_ONE, -3 * Q_ONE, 2 * Q_ONE);
    send_item(-2 * Q_ONE, Q_ONE, 3 * Q_ONE);
    send_item(1, Q_MAX, 0);                      // tiny a, one root clipped
    send_item(1, Q_MIN, Q_MIN);
    send_item(Q_MAX, Q_MAX, Q_MAX);
    send_item(Q_MIN, Q_MIN, Q_MIN);
    send_item(Q_MIN, Q_MAX, Q_MAX);
    send_item(Q_MAX, Q_MIN, Q_MIN);
    send_item(-1, 0, Q_MAX);
    send_item(Q_MIN, 0, 0);
    send_item(-1, -1, -1);
  endtask

  task automatic test_random(int n);
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
    logic signed [W-1:0] c;
    int                  mode;
    for (int i = 0; i < n; i++) begin
      a    = $urandom;
      b    = $urandom;
      c    = $urandom;
      mode = $urandom_range(0, 9);
      case (mode)
        0: a = 0;
        1: begin
          a = 0;
          if ($urandom_range(0, 1)) b = 0;
          if ($urandom_range(0, 3) == 0) c = 0;
        end
        2, 3, 4: begin
          // moderate magnitudes, roots mostly in range
          a = $signed(a) >>> $urandom_range(8, 28);
          b = $signed(b) >>> $urandom_range(4, 20);
          c = $signed(c) >>> $urandom_range(4, 20);
          if (a == 0) a = Q_ONE;
        end
        5: c = 0;
        default: ;
      endcase
      send_item(a, b, c);
    end
  endtask

  task automatic test_drain_pause();
    wait_drained();
    send_item(Q_ONE, -5 * Q_ONE, 6 * Q_ONE);
  endtask

  task automatic test_back_to_back(int n);
    no_idle = 1'b1;
    test_random(n);
    no_idle = 1'b0;
  endtask

  initial begin
    err_cnt     = 0;
    idle_cycles = 0;
    no_idle     = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_coef_a   = '0;
    in_coef_b   = '0;
    in_coef_c   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_drain_pause();
    test_random(500);
    test_back_to_back(200);
    test_drain_pause();
    test_random(300);

    @(negedge clk);
    in_valid = 1'b0;
    wait_drained();
    repeat (LATENCY + 20) @(posedge clk);
    if (err_cnt == 0 && pending_roots.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
